// ===== rtl/csfp_pkg.sv =====
// Package: shared constants and types for the frequency planner
`default_nettype none
package csfp_pkg;
  localparam int unsigned CrystalW     = 26;
  localparam logic [25:0] CrystalReset = 26'd25000000;
  localparam int unsigned AddrW        = 2;
  localparam logic [1:0]  RegCrystal   = 2'd0;
  localparam logic [31:0] FracDen      = 32'd1048575;
  localparam logic [31:0] VcoTarget    = 32'd800000000;
  localparam logic [31:0] LowFreq      = 32'd500000;
  localparam logic [31:0] HighFreq     = 32'd112500000;
  localparam logic [7:0]  PllBaseA     = 8'd26;
  localparam logic [7:0]  PllBaseB     = 8'd34;
  localparam logic [7:0]  MsBase       = 8'd42;
  localparam logic [7:0]  PllResetReg  = 8'd177;
  localparam logic [7:0]  CtrlBase     = 8'd16;
  localparam logic [7:0]  OeReg        = 8'd3;
  localparam logic [7:0]  PllResetA    = 8'h20;
  localparam logic [7:0]  PllResetB    = 8'h80;
  localparam logic [7:0]  CtrlBaseVal  = 8'h4F;
  localparam logic [7:0]  CtrlHigh     = 8'h40;
  localparam int unsigned NumWrites    = 19;

  // datapath operations requested by the controller
  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_DBL, OP_DIV, OP_FIX, OP_MUL, OP_FRAC
  } op_t;

  // divider operand selection
  typedef enum logic [1:0] {
    DV_VCO_T, DV_MULT, DV_NUM
  } dsel_t;

  typedef struct packed {
    op_t         op;
    logic        div_start;
    dsel_t       div_sel;
    logic        latch_q;
    logic [4:0]  beat;
  } cmd_t;

  typedef struct packed {
    logic        doubling_done;
    logic        div_busy;
    logic        skip;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/csfp_if.sv =====
// Interfaces: request and register-write channels
`default_nettype none
interface csfp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  output_index;
  logic [31:0] target_hz;
  logic        pll_select;
  modport source (output valid, output output_index, output target_hz, output pll_select,
                  input ready);
  modport sink (input valid, input output_index, input target_hz, input pll_select,
                output ready);
endinterface

interface csfp_wr_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic       last;
  modport source (output valid, output reg_addr, output reg_data, output last, input ready);
  modport sink (input valid, input reg_addr, input reg_data, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/csfp_div.sv =====
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
`default_nettype none
module csfp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient,
  output logic [31:0]      remainder
);
  logic [6:0]  count;
  logic [32:0] rem;
  logic [63:0] quo;
  logic [31:0] dsr;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[63]};
  assign diff    = shifted - {1'b0, dsr};

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= 7'd64;
      rem   <= '0;
      quo   <= dividend;
      dsr   <= divisor;
    end else if (count != 0) begin
      count <= count - 7'd1;
      if (!diff[32]) begin
        rem <= diff;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign busy      = (count != 0) || start;
  assign quotient  = quo;
  assign remainder = rem[31:0];
endmodule
`default_nettype wire

// ===== rtl/csfp_datapath.sv =====
// Datapath: frequency scaling, divisions, parameter packing and write formatting
`default_nettype none
module csfp_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire csfp_pkg::cmd_t          cmd,
  output csfp_pkg::sts_t               sts,
  input  wire logic [2:0]              in_index,
  input  wire logic [31:0]             in_freq,
  input  wire logic                    in_pll,
  input  wire logic [csfp_pkg::CrystalW-1:0] crystal_hz,
  output logic [7:0]                   wr_addr,
  output logic [7:0]                   wr_data
);
  logic [2:0]  idx;
  logic [31:0] freq, t, dv, vco, mult, num, q;
  logic        pll;
  logic [2:0]  rsteps;
  logic [63:0] dvd;
  logic [31:0] dsr;
  logic        div_busy;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] xtal;
  logic [31:0] p1a, p2a, p1b;
  logic [7:0]  rbits;
  logic [63:0] prod;
  logic        xzero;
  logic [31:0] qx;
  logic [11:0] q0;
  logic [20:0] qr;

  assign xtal  = {{(32-csfp_pkg::CrystalW){1'b0}}, crystal_hz};
  assign xzero = (xtal == 32'd0);

  // divider operand mux
  always_comb begin
    case (cmd.div_sel)
      csfp_pkg::DV_VCO_T: begin dvd = {32'd0, csfp_pkg::VcoTarget}; dsr = t; end
      csfp_pkg::DV_MULT:  begin dvd = {32'd0, vco}; dsr = xtal; end
      csfp_pkg::DV_NUM:   begin dvd = {32'd0, rem} * {32'd0, csfp_pkg::FracDen}; dsr = xtal; end
      default:            begin dvd = '0; dsr = 32'd1; end
    endcase
  end

  csfp_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dvd), .divisor(dsr),
    .busy(div_busy), .quotient(quo), .remainder(rem)
  );

  assign prod = {32'd0, dv} * {32'd0, t};

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      csfp_pkg::OP_LOAD: begin
        idx <= in_index; freq <= in_freq; pll <= in_pll; t <= in_freq; rsteps <= '0;
      end
      csfp_pkg::OP_DBL: begin
        t <= {t[30:0], 1'b0}; rsteps <= rsteps + 3'd1;
      end
      csfp_pkg::OP_DIV: dv <= quo[31:0];
      csfp_pkg::OP_FIX: begin
        if ({dv[31:1], 1'b0} < 32'd6) dv <= 32'd6;
        else dv <= {dv[31:1], 1'b0};
      end
      csfp_pkg::OP_MUL: vco <= prod[31:0];
      csfp_pkg::OP_FRAC: begin
        mult <= xzero ? 32'd0 : quo[31:0];
      end
      default: ;
    endcase
    if (cmd.latch_q) num <= xzero ? 32'd0 : quo[31:0];
  end

  // 128*num / (2^20 - 1): high part plus one correction step
  assign qx = {num[24:0], 7'd0};
  assign q0 = qx[31:20];
  assign qr = {1'b0, qx[19:0]} + {9'd0, q0};
  assign q  = (qr >= csfp_pkg::FracDen[20:0]) ? {20'd0, q0} + 32'd1 : {20'd0, q0};

  assign sts.doubling_done = (t >= csfp_pkg::LowFreq) || (rsteps == 3'd7);
  assign sts.div_busy      = div_busy;
  assign sts.skip          = (in_index > 3'd2) || (in_freq == 32'd0);

  assign rbits = {1'b0, rsteps, 4'd0};
  assign p1a = {mult[24:0], 7'd0} + q - 32'd512;
  assign p2a = {num[24:0], 7'd0} - csfp_pkg::FracDen * q;
  assign p1b = {dv[24:0], 7'd0} - 32'd512;

  // write formatting per beat
  always_comb begin
    wr_addr = 8'd0;
    wr_data = 8'd0;
    if (cmd.beat < 5'd8) begin
      wr_addr = (pll ? csfp_pkg::PllBaseB : csfp_pkg::PllBaseA) + {5'd0, cmd.beat[2:0]};
      case (cmd.beat[2:0])
        3'd0: wr_data = csfp_pkg::FracDen[15:8];
        3'd1: wr_data = csfp_pkg::FracDen[7:0];
        3'd2: wr_data = {6'd0, p1a[17:16]};
        3'd3: wr_data = p1a[15:8];
        3'd4: wr_data = p1a[7:0];
        3'd5: wr_data = {csfp_pkg::FracDen[19:16], p2a[19:16]};
        3'd6: wr_data = p2a[15:8];
        default: wr_data = p2a[7:0];
      endcase
    end else if (cmd.beat < 5'd16) begin
      wr_addr = csfp_pkg::MsBase + {2'd0, idx, 3'd0} + {5'd0, cmd.beat[2:0]};
      case (cmd.beat[2:0])
        3'd0: wr_data = 8'd0;
        3'd1: wr_data = 8'd1;
        3'd2: wr_data = {6'd0, p1b[17:16]} | rbits;
        3'd3: wr_data = p1b[15:8];
        3'd4: wr_data = p1b[7:0];
        default: wr_data = 8'd0;
      endcase
    end else if (cmd.beat == 5'd16) begin
      wr_addr = csfp_pkg::PllResetReg;
      wr_data = pll ? csfp_pkg::PllResetB : csfp_pkg::PllResetA;
    end else if (cmd.beat == 5'd17) begin
      wr_addr = csfp_pkg::CtrlBase + {5'd0, idx};
      wr_data = csfp_pkg::CtrlBaseVal | {2'd0, pll, 5'd0}
              | ((freq > csfp_pkg::HighFreq) ? csfp_pkg::CtrlHigh : 8'd0);
    end else begin
      wr_addr = csfp_pkg::OeReg;
      wr_data = 8'd0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/csfp_ctrl.sv =====
// Controller: sequences the computation steps and the register-write beats
`default_nettype none
module csfp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_last,
  output csfp_pkg::cmd_t      cmd,
  input  wire csfp_pkg::sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_DBL, S_DIV0, S_DIVW0, S_FIX, S_MUL, S_DIV1, S_DIVW1,
    S_DIV2, S_DIVW2, S_EMIT
  } state_t;

  state_t     state;
  logic [4:0] beat;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign out_last  = (beat == 5'(csfp_pkg::NumWrites - 1));

  // command decode
  always_comb begin
    cmd = '0;
    cmd.beat = beat;
    case (state)
      S_IDLE:  if (in_valid) cmd.op = csfp_pkg::OP_LOAD;
      S_DBL:   if (!sts.doubling_done) cmd.op = csfp_pkg::OP_DBL;
      S_DIV0:  begin cmd.div_start = 1'b1; cmd.div_sel = csfp_pkg::DV_VCO_T; end
      S_DIVW0: if (!sts.div_busy) cmd.op = csfp_pkg::OP_DIV;
      S_FIX:   cmd.op = csfp_pkg::OP_FIX;
      S_MUL:   cmd.op = csfp_pkg::OP_MUL;
      S_DIV1:  begin cmd.div_start = 1'b1; cmd.div_sel = csfp_pkg::DV_MULT; end
      S_DIVW1: if (!sts.div_busy) cmd.op = csfp_pkg::OP_FRAC;
      S_DIV2:  begin cmd.div_start = 1'b1; cmd.div_sel = csfp_pkg::DV_NUM; end
      S_DIVW2: begin
        cmd.div_sel = csfp_pkg::DV_NUM;
        cmd.latch_q = !sts.div_busy;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      beat  <= '0;
    end else begin
      case (state)
        S_IDLE:  if (in_valid && !sts.skip) begin state <= S_DBL; beat <= '0; end
        S_DBL:   if (sts.doubling_done) state <= S_DIV0;
        S_DIV0:  state <= S_DIVW0;
        S_DIVW0: if (!sts.div_busy) state <= S_FIX;
        S_FIX:   state <= S_MUL;
        S_MUL:   state <= S_DIV1;
        S_DIV1:  state <= S_DIVW1;
        S_DIVW1: if (!sts.div_busy) state <= S_DIV2;
        S_DIV2:  state <= S_DIVW2;
        S_DIVW2: if (!sts.div_busy) state <= S_EMIT;
        S_EMIT:  if (out_ready) begin
          if (out_last) begin
            state <= S_IDLE;
            beat  <= '0;
          end else begin
            beat <= beat + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/clock_synth_frequency_plan.sv =====
// Each request runs up to seven doubling steps and three 64-step divisions in one shared
// radix-2 divider before its first write beat; no new request is taken until its last beat.
// 19 write beats per request at one per cycle while the sink is ready.
// Requests with index above 2 or zero frequency are accepted with no writes.
// Synchronous active-high reset; crystal register resets to 25 MHz.
`default_nettype none
module clock_synth_frequency_plan (
  input  wire logic  clk,
  input  wire logic  rst,
  csfp_req_if.sink   req,
  csfp_wr_if.source  wr,
  input  wire logic  psel,
  input  wire logic  penable,
  input  wire logic  pwrite,
  input  wire logic [csfp_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [csfp_pkg::CrystalW-1:0] crystal_hz;
  csfp_pkg::cmd_t cmd;
  csfp_pkg::sts_t sts;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz <= csfp_pkg::CrystalReset;
    end else if (psel && penable && pwrite && paddr == {csfp_pkg::RegCrystal}) begin
      crystal_hz <= pwdata[csfp_pkg::CrystalW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == csfp_pkg::RegCrystal)
                ? {{(32-csfp_pkg::CrystalW){1'b0}}, crystal_hz} : 32'd0;

  csfp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(wr.valid), .out_ready(wr.ready), .out_last(wr.last),
    .cmd(cmd), .sts(sts)
  );

  csfp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_index(req.output_index), .in_freq(req.target_hz), .in_pll(req.pll_select),
    .crystal_hz(crystal_hz), .wr_addr(wr.reg_addr), .wr_data(wr.reg_data)
  );
endmodule
`default_nettype wire

// ===== rtl/csfp_checker.sv =====
// Checker: port-level properties of the frequency planner, bound to the top level
`default_nettype none
module csfp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic wr_valid,
  input wire logic wr_ready,
  input wire logic wr_last,
  input wire logic [7:0] wr_addr
);
  // no request taken while writes are pending
  a_excl: assert property (@(posedge clk) disable iff (rst) !(wr_valid && req_ready))
    else $error("request ready during write beats");
  // sequence ends on register 3
  a_last: assert property (@(posedge clk) disable iff (rst) wr_valid && wr_last |-> wr_addr == 8'd3)
    else $error("last beat not on register 3");
  // after last accepted beat, block is idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_ready && wr_last |=> req_ready)
    else $error("not idle after sequence");
  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr_ready |=> wr_valid && $stable(wr_addr))
    else $error("write beat dropped");
endmodule

bind clock_synth_frequency_plan csfp_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .wr_valid(wr.valid), .wr_ready(wr.ready), .wr_last(wr.last), .wr_addr(wr.reg_addr)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the clock synthesizer frequency planner: predicted register writes vs. DUT
`timescale 1ns / 100ps
module tb_top;
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } wr_beat_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [csfp_pkg::AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  csfp_req_if req();
  csfp_wr_if  wr();

  clock_synth_frequency_plan uut (
    .clk(clk), .rst(rst), .req(req.sink), .wr(wr.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wr_beat_t   pending_writes[$];
  logic [25:0] xtal_hz;
  int  mismatches;
  bit  failed;
  bit  idle_en;
  int  stall_cycles;
  int  watchdog;
  localparam int WatchdogLimit = 20000;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // encode one divider parameter set into eight bytes
  function automatic void pack_params(input logic [31:0] whole, input logic [31:0] num,
                                      input logic [31:0] den, input logic [7:0] rbits,
                                      output logic [7:0] b [8]);
    logic [31:0] q, p1, p2;
    q  = (den != 0) ? (32'd128 * num) / den : 32'd0;
    p1 = 32'd128 * whole + q - 32'd512;
    p2 = 32'd128 * num - den * q;
    b[0] = den[15:8];
    b[1] = den[7:0];
    b[2] = {6'd0, p1[17:16]} | rbits;
    b[3] = p1[15:8];
    b[4] = p1[7:0];
    b[5] = {den[19:16], p2[19:16]};
    b[6] = p2[15:8];
    b[7] = p2[7:0];
  endfunction

  // compute the write sequence for one frequency request
  task automatic plan_writes(input logic [2:0] idx, input logic [31:0] freq, input logic pll);
    logic [31:0] t, dv, vco, mult, num, ctrl;
    logic [63:0] frac;
    logic [7:0]  rbits;
    logic [7:0]  b [8];
    if (idx > 3'd2 || freq == 0) return;
    t = freq;
    rbits = 8'd0;
    while (t < csfp_pkg::LowFreq && rbits < 8'h70) begin
      t = t << 1;
      rbits = rbits + 8'h10;
    end
    dv = csfp_pkg::VcoTarget / t;
    if (dv[0]) dv = dv - 1;
    if (dv < 6) dv = 6;
    vco = dv * t;
    mult = 0;
    num = 0;
    if (xtal_hz != 0) begin
      mult = vco / xtal_hz;
      frac = (64'(vco % xtal_hz) * 64'(csfp_pkg::FracDen)) / xtal_hz;
      num = frac[31:0];
    end
    pack_params(mult, num, csfp_pkg::FracDen, 8'd0, b);
    for (int i = 0; i < 8; i++)
      pending_writes.push_back({(pll ? csfp_pkg::PllBaseB : csfp_pkg::PllBaseA) + 8'(i),
                                b[i], 1'b0});
    pack_params(dv, 32'd0, 32'd1, rbits, b);
    for (int i = 0; i < 8; i++)
      pending_writes.push_back({csfp_pkg::MsBase + 8'(idx) * 8'd8 + 8'(i), b[i], 1'b0});
    pending_writes.push_back({csfp_pkg::PllResetReg,
                              pll ? csfp_pkg::PllResetB : csfp_pkg::PllResetA, 1'b0});
    ctrl = 32'(csfp_pkg::CtrlBaseVal) | (32'(pll) << 5);
    if (freq > csfp_pkg::HighFreq) ctrl = ctrl | 32'(csfp_pkg::CtrlHigh);
    pending_writes.push_back({csfp_pkg::CtrlBase + 8'(idx), ctrl[7:0], 1'b0});
    pending_writes.push_back({csfp_pkg::OeReg, 8'd0, 1'b1});
  endtask

  // send one request beat, with random idle bursts before it
  task automatic send_request(input logic [2:0] idx, input logic [31:0] freq, input logic pll);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.output_index <= idx;
    req.target_hz    <= freq;
    req.pll_select   <= pll;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    plan_writes(idx, freq, pll);
  endtask

  // wait for all writes, then let the block settle before touching config
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // APB write: setup then access phase
  task automatic write_crystal(input logic [25:0] hz);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= csfp_pkg::RegCrystal;
    pwdata  <= 32'(hz);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    xtal_hz = hz;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] rand_freq();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 500000);
      1: return $urandom_range(500000, 8000000);
      2: return $urandom_range(8000000, 112500000);
      3: return $urandom_range(112500000, 300000000);
      4: return $urandom();
      default: return $urandom_range(1, 4000);
    endcase
  endfunction

  // field extremes, both PLLs, every output, ignored requests
  task automatic test_directed();
    send_request(3'd0, 32'd1, 1'b0);
    send_request(3'd1, 32'd499999, 1'b1);
    send_request(3'd2, 32'd500000, 1'b0);
    send_request(3'd0, 32'd10000000, 1'b1);
    send_request(3'd1, 32'd112500000, 1'b0);
    send_request(3'd2, 32'd112500001, 1'b1);
    send_request(3'd0, 32'd200000000, 1'b0);
    send_request(3'd1, 32'hFFFFFFFF, 1'b1);
    send_request(3'd2, 32'h80000000, 1'b0);
    send_request(3'd3, 32'd10000000, 1'b0);
    send_request(3'd7, 32'hFFFFFFFF, 1'b1);
    send_request(3'd4, 32'd1, 1'b0);
    send_request(3'd0, 32'd0, 1'b0);
    send_request(3'd2, 32'd0, 1'b1);
    send_request(3'd1, 32'd3000, 1'b0);
    send_request(3'd0, 32'd55555555, 1'b1);
  endtask

  // random requests, mostly valid ones
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_request(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, 2)),
                   ($urandom_range(0, 19) == 0) ? 32'd0 : rand_freq(),
                   1'($urandom()));
  endtask

  // sender holds off until every write is back
  task automatic test_hold_off();
    send_request(3'd2, 32'd7000000, 1'b1);
    req.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    send_request(3'd0, 32'd7000000, 1'b0);
  endtask

  // write-channel checker
  always @(posedge clk) begin
    wr_beat_t got, exp_w;
    if (!rst && wr.valid && wr.ready) begin
      got = {wr.reg_addr, wr.reg_data, wr.last};
      if (pending_writes.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected write beat %h", got);
      end else begin
        exp_w = pending_writes.pop_front();
        if (got !== exp_w) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("write mismatch: exp addr %0d data %h last %b, got addr %0d data %h last %b",
                     exp_w.addr, exp_w.data, exp_w.last, got.addr, got.data, got.last);
        end
      end
    end
  end

  // sink stalls in random bursts
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      wr.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_cycles <= $urandom_range(0, 2);
      wr.ready <= 1'b0;
    end else begin
      wr.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (wr.valid && wr.ready) || psel)
      watchdog <= 0;
    else if (watchdog >= WatchdogLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else
      watchdog <= watchdog + 1;
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.output_index = '0;
    req.target_hz = '0;
    req.pll_select = 1'b0;
    wr.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    xtal_hz = csfp_pkg::CrystalReset;
    mismatches = 0;
    failed = 1'b0;
    idle_en = 1'b1;
    stall_cycles = 0;
    watchdog = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_hold_off();
    test_random(60);
    write_crystal(26'd10000000);
    test_directed();
    test_random(40);
    write_crystal(26'd40000000);
    test_random(40);
    write_crystal(26'd0);
    test_random(15);
    write_crystal(26'h3FFFFFF);
    test_random(15);
    write_crystal(26'd27000000);
    idle_en = 1'b0;
    test_random(40);

    req.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end
endmodule
